// ----- hdl/adpcm_pkg.sv -----
`default_nettype none

package adpcm_pkg;

    // fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int INDEX_W   = 24;
    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;

    // history and multiply-add widths
    localparam int HIST_W    = 40;
    localparam int COEF_W    = 8;
    localparam int COEF_FRAC = 6;
    localparam int PROD_W    = HIST_W + COEF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int HQ_W      = ACC_W - COEF_FRAC;

    // shift nibble that gives a gain of one
    localparam logic [NIB_W-1:0] SHIFT_UNITY = 4'd12;

    // filter index mapping
    localparam logic [2:0] FILTER_MAX = 3'd4;

    // byte positions inside a block
    localparam logic [3:0] POS_HEADER = 4'd0;
    localparam logic [3:0] POS_FLAGS  = 4'd1;
    localparam logic [3:0] POS_FIRST  = 4'd2;

    // flag bits
    localparam int FLAG_END        = 0;
    localparam int FLAG_LOOP       = 1;
    localparam int FLAG_LOOP_START = 2;

    // silence marker
    localparam logic [BYTE_W-1:0] SILENCE_HEADER = 8'h00;
    localparam logic [BYTE_W-1:0] SILENCE_FLAGS  = 8'h07;
    localparam logic [BYTE_W-1:0] SILENCE_BYTE   = 8'h77;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_FINISH
    } state_t;

    // control from the sequencer to the multiply-add unit
    typedef struct packed {
        logic mul_a;
        logic mul_b;
        logic finish;
        logic second;
    } mac_ctrl_t;

    // first tap coefficients, six fractional bits
    function automatic logic signed [COEF_W-1:0] coef_a(input logic [2:0] f);
        logic signed [COEF_W-1:0] c;
        case (f)
            3'd1:    c = 8'sd60;
            3'd2:    c = 8'sd115;
            3'd3:    c = 8'sd98;
            3'd4:    c = 8'sd122;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    // second tap coefficients, six fractional bits
    function automatic logic signed [COEF_W-1:0] coef_b(input logic [2:0] f);
        logic signed [COEF_W-1:0] c;
        case (f)
            3'd2:    c = -8'sd52;
            3'd3:    c = -8'sd55;
            3'd4:    c = -8'sd60;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/adpcm_block_decoder.sv -----
// a header or flags byte is taken while idle and gives no item; each nibble of
// a sample byte runs three multiply-add steps (two taps and a finish), and the
// second finish loads the pair into the output register once it is free; no new
// byte is taken until that pair has been loaded
// reset: synchronous active-low aresetn clears history, block position,
// header state, sample counter and both channel handshakes
`default_nettype none

module adpcm_block_decoder
    import adpcm_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int INDEX_BITS = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // stream_byte
    input  wire logic [7:0]  s_tdata,
    // start_of_sound
    input  wire logic        s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // first_sample [15:0], second_sample [31:16], sample_index [55:32]
    output logic [55:0]      m_tdata,
    // loop_start_mark [0], looping_seen [1], end_mark [2]
    output logic [2:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    localparam int IDX_W = (INDEX_BITS > INDEX_W) ? INDEX_BITS : INDEX_W;
    localparam logic [INDEX_BITS-1:0] CNT_MAX = '1;

    // header state
    logic [3:0]             pos_reg, pos_next;
    logic [NIB_W-1:0]       shift_reg, shift_next;
    logic [2:0]             filter_reg, filter_next;
    logic [BYTE_W-1:0]      flags_reg, flags_next;
    logic                   looping_reg, looping_next;
    logic                   hzero_reg, hzero_next;
    logic [INDEX_BITS-1:0]  cnt_reg, cnt_next;

    // item in work
    logic [BYTE_W-1:0]      byte_reg;
    logic [INDEX_W-1:0]     pidx_reg;
    logic                   pstart_reg;
    logic                   ploop_reg;
    logic                   pend_reg;
    logic [SAMPLE_W-1:0]    first_reg;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]    m_first_reg;
    logic [SAMPLE_W-1:0]    m_second_reg;
    logic [INDEX_W-1:0]     m_idx_reg;
    logic [2:0]             m_user_reg;

    logic                   accept;
    logic [3:0]             pos_eff;
    logic                   is_sample;
    logic                   go;
    logic                   out_free;
    logic                   load_out;
    logic                   first_pair;
    logic [IDX_W-1:0]       cnt_wide;
    logic [NIB_W-1:0]       nibble;
    logic signed [SAMPLE_W-1:0] sample;
    mac_ctrl_t              ctrl;

    assign accept    = s_tvalid && s_tready;
    assign pos_eff   = s_tuser ? POS_HEADER : pos_reg;
    assign is_sample = (pos_eff != POS_HEADER) && (pos_eff != POS_FLAGS);
    assign go        = accept && is_sample;
    assign out_free  = !m_valid_reg || m_tready;
    assign load_out  = ctrl.finish && ctrl.second;
    assign first_pair = (pos_eff == POS_FIRST);
    assign cnt_wide  = IDX_W'(cnt_reg);
    assign nibble    = ctrl.second ? byte_reg[7:4] : byte_reg[3:0];

    adpcm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (go),
        .out_free (out_free),
        .ready    (s_tready),
        .ctrl     (ctrl)
    );

    adpcm_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .hist_clear    (accept && s_tuser),
        .nibble        (nibble),
        .shift_nibble  (shift_reg),
        .filter_select (filter_reg),
        .sample        (sample)
    );

    // block header, flags and sample counter
    always_comb begin
        pos_next     = pos_reg;
        shift_next   = shift_reg;
        filter_next  = filter_reg;
        flags_next   = flags_reg;
        looping_next = looping_reg;
        hzero_next   = hzero_reg;
        cnt_next     = cnt_reg;
        if (accept) begin
            pos_next = pos_eff + 4'd1;
            if (s_tuser) begin
                looping_next = 1'b0;
                cnt_next     = '0;
            end
            if (pos_eff == POS_HEADER) begin
                shift_next  = s_tdata[3:0];
                filter_next = (s_tdata[6:4] > FILTER_MAX) ? 3'd0 : s_tdata[6:4];
                hzero_next  = (s_tdata == SILENCE_HEADER);
            end else if (pos_eff == POS_FLAGS) begin
                flags_next = s_tdata;
                if (s_tdata[FLAG_LOOP]) begin
                    looping_next = 1'b1;
                end
            end else begin
                if (cnt_reg >= CNT_MAX - INDEX_BITS'(1)) begin
                    cnt_next = CNT_MAX;
                end else begin
                    cnt_next = cnt_reg + INDEX_BITS'(2);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            shift_reg   <= '0;
            filter_reg  <= '0;
            flags_reg   <= '0;
            looping_reg <= 1'b0;
            hzero_reg   <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            pos_reg     <= pos_next;
            shift_reg   <= shift_next;
            filter_reg  <= filter_next;
            flags_reg   <= flags_next;
            looping_reg <= looping_next;
            hzero_reg   <= hzero_next;
            cnt_reg     <= cnt_next;
        end
    end

    // capture the sample byte and its marks
    always_ff @(posedge aclk) begin
        if (go) begin
            byte_reg   <= s_tdata;
            pidx_reg   <= cnt_wide[INDEX_W-1:0];
            pstart_reg <= first_pair && flags_reg[FLAG_LOOP_START];
            ploop_reg  <= looping_reg;
            pend_reg   <= first_pair && (flags_reg[FLAG_END] ||
                          (hzero_reg && flags_reg == SILENCE_FLAGS &&
                           s_tdata == SILENCE_BYTE));
        end
        if (ctrl.finish && !ctrl.second) begin
            first_reg <= sample;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_first_reg  <= first_reg;
            m_second_reg <= sample;
            m_idx_reg    <= pidx_reg;
            m_user_reg   <= {pend_reg, ploop_reg, pstart_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_idx_reg, m_second_reg, m_first_reg};
    assign m_tuser  = m_user_reg;

    // header and flags bytes never stall the input
    a_header_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_sample |=> s_tready)
        else $error("header item stalled the input");

    // a sample byte occupies the unit
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        go |=> !s_tready)
        else $error("input ready while decoding");

    // second finish always presents an item
    a_item_out: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid)
        else $error("decoded item lost");

endmodule

`default_nettype wire

// ----- hdl/adpcm_mac.sv -----
`default_nettype none

module adpcm_mac
    import adpcm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire mac_ctrl_t                  ctrl,
    input  wire logic                       hist_clear,
    input  wire logic [NIB_W-1:0]           nibble,
    input  wire logic [NIB_W-1:0]           shift_nibble,
    input  wire logic [2:0]                 filter_select,
    output logic signed [SAMPLE_W-1:0]      sample
);

    localparam int BASE_SH = FRAC_BITS + COEF_FRAC;
    localparam logic signed [HQ_W-1:0] ROUND_BIAS = (HQ_W'(1) << FRAC_BITS) - HQ_W'(1);
    localparam logic signed [HQ_W-1:0] SMP_MAX = HQ_W'(32767);
    localparam logic signed [HQ_W-1:0] SMP_MIN = -HQ_W'(32768);
    localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
    localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

    logic signed [HIST_W-1:0] hist_one_reg, hist_one_next;
    logic signed [HIST_W-1:0] hist_two_reg, hist_two_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic signed [ACC_W-1:0]  nib_ext;
    logic signed [ACC_W-1:0]  term;
    logic [NIB_W-1:0]         lsh;
    logic [1:0]               rsh;
    logic signed [HIST_W-1:0] op_hist;
    logic signed [COEF_W-1:0] op_coef;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [HQ_W-1:0]   hq;
    logic signed [HIST_W-1:0] hsat;
    logic signed [HQ_W-1:0]   hround;
    logic signed [HQ_W-1:0]   tq;

    // scaled nibble term
    assign nib_ext = {{(ACC_W-NIB_W){nibble[NIB_W-1]}}, nibble};
    assign lsh     = SHIFT_UNITY - shift_nibble;
    assign rsh     = 2'(shift_nibble - SHIFT_UNITY);

    always_comb begin
        if (shift_nibble <= SHIFT_UNITY) begin
            term = (nib_ext <<< lsh) <<< BASE_SH;
        end else begin
            term = (nib_ext >>> rsh) <<< BASE_SH;
        end
    end

    // shared multiplier, one tap per step
    assign op_hist  = ctrl.mul_a ? hist_one_reg : hist_two_reg;
    assign op_coef  = ctrl.mul_a ? coef_a(filter_select) : coef_b(filter_select);
    assign prod     = op_hist * op_coef;
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.mul_a) begin
            acc_next = term + prod_ext;
        end else if (ctrl.mul_b) begin
            acc_next = acc_reg + prod_ext;
        end
    end

    // drop coefficient fraction (floor) and saturate history
    assign hq = HQ_W'(acc_reg >>> COEF_FRAC);

    always_comb begin
        if (hq > HQ_W'(HIST_MAX)) begin
            hsat = HIST_MAX;
        end else if (hq < HQ_W'(HIST_MIN)) begin
            hsat = HIST_MIN;
        end else begin
            hsat = HIST_W'(hq);
        end
    end

    // pcm value: truncate toward zero then clamp
    assign hround = hq[HQ_W-1] ? hq + ROUND_BIAS : hq;
    assign tq     = hround >>> FRAC_BITS;

    always_comb begin
        if (tq > SMP_MAX) begin
            sample = 16'sh7fff;
        end else if (tq < SMP_MIN) begin
            sample = -16'sh8000;
        end else begin
            sample = SAMPLE_W'(tq);
        end
    end

    // history update
    always_comb begin
        hist_one_next = hist_one_reg;
        hist_two_next = hist_two_reg;
        if (hist_clear) begin
            hist_one_next = '0;
            hist_two_next = '0;
        end else if (ctrl.finish) begin
            hist_one_next = hsat;
            hist_two_next = hist_one_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_one_reg <= '0;
            hist_two_reg <= '0;
        end else begin
            hist_one_reg <= hist_one_next;
            hist_two_reg <= hist_two_next;
        end
    end

    // accumulator
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // history shifts by one place on each finished nibble
    a_hist_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.finish && !hist_clear |=> hist_two_reg == $past(hist_one_reg))
        else $error("history did not shift on finish");

endmodule

`default_nettype wire

// ----- hdl/adpcm_seq.sv -----
`default_nettype none

module adpcm_seq
    import adpcm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic go,
    input  wire logic out_free,
    output logic      ready,
    output mac_ctrl_t ctrl
);

    state_t state_reg, state_next;
    logic   nib_reg, nib_next;

    // next state
    always_comb begin
        state_next = state_reg;
        nib_next   = nib_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (go) begin
                    state_next = ST_MUL_A;
                    nib_next   = 1'b0;
                end
            end
            ST_MUL_A: begin
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!nib_reg) begin
                    state_next = ST_MUL_A;
                    nib_next   = 1'b1;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        ready       = 1'b0;
        ctrl.mul_a  = 1'b0;
        ctrl.mul_b  = 1'b0;
        ctrl.finish = 1'b0;
        ctrl.second = nib_reg;
        unique case (state_reg)
            ST_IDLE:   ready       = 1'b1;
            ST_MUL_A:  ctrl.mul_a  = 1'b1;
            ST_MUL_B:  ctrl.mul_b  = 1'b1;
            ST_FINISH: ctrl.finish = !nib_reg || out_free;
            default:   ready       = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            nib_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            nib_reg   <= nib_next;
        end
    end

    // each nibble runs both taps before finishing
    a_tap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL_A |=> state_reg == ST_MUL_B)
        else $error("second tap skipped");

    a_tap_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL_B |=> state_reg == ST_FINISH)
        else $error("finish step skipped");

endmodule

`default_nettype wire

// ----- bench/adpcm_block_decoder_tb.sv -----
module adpcm_block_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import adpcm_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam longint HIST_HI = (longint'(1) <<< (HIST_W - 1)) - 1;
    localparam longint HIST_LO = -HIST_HI - 1;
    localparam logic [INDEX_W-1:0] INDEX_TOP = {INDEX_W{1'b1}};
    localparam int RANDOM_BYTES = 1100;

    // one decoded pair as it leaves the block
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] first_sample;
        logic signed [SAMPLE_W-1:0] second_sample;
        logic [INDEX_W-1:0]         sample_index;
        logic                       loop_start_mark;
        logic                       looping_seen;
        logic                       end_mark;
    } pcm_item_t;

    // one directed stimulus row, with a hand-worked result where obvious
    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              start_of_sound;
        logic              has_fixed;
        pcm_item_t         fixed_res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    adpcm_block_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // clock, 10 ns period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // decoder state mirrored by the predictor
    logic [3:0]         blk_pos = '0;
    logic [3:0]         shift_q = '0;
    logic [2:0]         filt_q = '0;
    logic [7:0]         flags_q = '0;
    logic               looping_q = 1'b0;
    logic               hdr_zero_q = 1'b0;
    longint             hist1 = 0;
    longint             hist2 = 0;
    logic [INDEX_W-1:0] sample_cnt = '0;

    pcm_item_t pcm_expected[$];
    int        fail_count = 0;
    int        rx_count = 0;
    int        bytes_sent = 0;
    bit        gaps_on = 1'b1;
    int        rx_hold = 0;
    int        rx_gap = 0;

    // directed stimulus: header, flags and sample bytes of short blocks
    stim_row_t directed_rows [22] = '{
        // unity gain, filter 0, all flags set
        '{8'h0C, 1'b1, 1'b0, '0},
        '{8'h07, 1'b0, 1'b0, '0},
        '{8'h87, 1'b0, 1'b1, '{16'sd7, -16'sd8, 24'd0, 1'b1, 1'b1, 1'b1}},
        '{8'h0F, 1'b0, 1'b1, '{-16'sd1, 16'sd0, 24'd2, 1'b0, 1'b1, 1'b0}},
        // silence marker, full gain extremes
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h07, 1'b0, 1'b0, '0},
        '{8'h77, 1'b0, 1'b1, '{16'sd28672, 16'sd28672, 24'd0, 1'b1, 1'b1, 1'b1}},
        '{8'h88, 1'b0, 1'b1, '{-16'sd32768, -16'sd32768, 24'd2, 1'b0, 1'b1, 1'b0}},
        // strongest filter with a small right shift
        '{8'h4D, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h88, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'hF7, 1'b0, 1'b0, '0},
        // out-of-range filter index, largest right shift, loop flag only
        '{8'h7F, 1'b1, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'hF8, 1'b0, 1'b1, '{-16'sd1, -16'sd1, 24'd0, 1'b0, 1'b1, 1'b0}},
        '{8'h17, 1'b0, 1'b1, '{16'sd0, 16'sd0, 24'd2, 1'b0, 1'b1, 1'b0}},
        // filter 2 with the end flag
        '{8'h2C, 1'b1, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h08, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0}
    };

    // prediction taps, six fractional bits
    function automatic longint first_tap(input logic [2:0] f);
        case (f)
            3'd1:    return 60;
            3'd2:    return 115;
            3'd3:    return 98;
            3'd4:    return 122;
            default: return 0;
        endcase
    endfunction

    function automatic longint second_tap(input logic [2:0] f);
        case (f)
            3'd2:    return -52;
            3'd3:    return -55;
            3'd4:    return -60;
            default: return 0;
        endcase
    endfunction

    // scale one nibble, run it through the filter and update the history
    function automatic logic signed [SAMPLE_W-1:0] nibble_to_pcm(input logic [3:0] nib);
        longint s, term, acc, h, t;
        int     sh;
        s  = nib[3] ? longint'(nib) - 16 : longint'(nib);
        sh = int'(SHIFT_UNITY) - int'(shift_q);
        if (sh >= 0) begin
            term = s <<< (sh + FRAC_BITS + COEF_FRAC);
        end else begin
            term = (s >>> (-sh)) <<< (FRAC_BITS + COEF_FRAC);
        end
        acc = term + hist1 * first_tap(filt_q) + hist2 * second_tap(filt_q);
        h = acc >>> COEF_FRAC;
        if (h > HIST_HI) h = HIST_HI;
        if (h < HIST_LO) h = HIST_LO;
        hist2 = hist1;
        hist1 = h;
        // truncate toward zero, then clamp to the sample range
        t = (h >= 0) ? (h >>> FRAC_BITS) : -((-h) >>> FRAC_BITS);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return 16'(t);
    endfunction

    // take one stream byte, returns 1 when it yields a sample pair
    function automatic bit predict_byte(input logic [7:0] b, input logic sos,
                                        output pcm_item_t r);
        logic [3:0] pos;
        logic [2:0] f;
        r = '0;
        if (sos) begin
            hist1 = 0;
            hist2 = 0;
            blk_pos = '0;
            looping_q = 1'b0;
            sample_cnt = '0;
        end
        pos = blk_pos;
        blk_pos = blk_pos + 4'd1;
        if (pos == POS_HEADER) begin
            f = b[6:4];
            shift_q = b[3:0];
            filt_q = (f > FILTER_MAX) ? 3'd0 : f;
            hdr_zero_q = (b == SILENCE_HEADER);
            return 1'b0;
        end
        if (pos == POS_FLAGS) begin
            flags_q = b;
            if (b[FLAG_LOOP]) looping_q = 1'b1;
            return 1'b0;
        end
        r.first_sample    = nibble_to_pcm(b[3:0]);
        r.second_sample   = nibble_to_pcm(b[7:4]);
        r.sample_index    = sample_cnt;
        r.loop_start_mark = (pos == POS_FIRST) && flags_q[FLAG_LOOP_START];
        r.looping_seen    = looping_q;
        r.end_mark        = (pos == POS_FIRST) && (flags_q[FLAG_END] ||
                            (hdr_zero_q && flags_q == SILENCE_FLAGS && b == SILENCE_BYTE));
        if (sample_cnt >= INDEX_TOP - INDEX_W'(1)) begin
            sample_cnt = INDEX_TOP;
        end else begin
            sample_cnt = sample_cnt + INDEX_W'(2);
        end
        return 1'b1;
    endfunction

    // offer one byte from a falling edge until it is taken, then log any pair it yields
    task automatic put_byte(input logic [7:0] b, input logic sos, input logic has_fixed,
                            input pcm_item_t fixed_res);
        pcm_item_t res;
        bit        gives;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gives = predict_byte(b, sos, res);
        if (gives) pcm_expected = {pcm_expected, (has_fixed ? fixed_res : res)};
        bytes_sent++;
        @(negedge aclk);
    endtask

    // a sound of a few well-formed blocks, sometimes cut short
    task automatic send_sound();
        int         n_blocks, last_pos, pick;
        logic [7:0] hdr, flg, smp;
        logic       sos;
        logic [3:0] sh;
        n_blocks = $urandom_range(1, 4);
        sos = ($urandom_range(0, 7) != 0);
        for (int k = 0; k < n_blocks; k++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                hdr = SILENCE_HEADER;
                flg = SILENCE_FLAGS;
            end else begin
                sh = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(13, 15))
                                                 : 4'($urandom_range(0, 12));
                hdr = {1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), sh};
                flg = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 7));
            end
            last_pos = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : 15;
            put_byte(hdr, sos && (k == 0), 1'b0, '0);
            if (last_pos == 0) return;
            put_byte(flg, 1'b0, 1'b0, '0);
            for (int p = 2; p <= last_pos; p++) begin
                if (pick == 0 && p == 2) begin
                    smp = SILENCE_BYTE;
                end else if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       smp = 8'h77;
                        1:       smp = 8'h88;
                        2:       smp = 8'h78;
                        default: smp = 8'h87;
                    endcase
                end else begin
                    smp = 8'($urandom_range(0, 255));
                end
                put_byte(smp, 1'b0, 1'b0, '0);
            end
            if (last_pos < 15) return;
        end
    endtask

    // result side ready, with a long hold on request and short random bursts
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                m_tready <= 1'b0;
                rx_gap--;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                rx_gap = $urandom_range(1, 5) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare each accepted pair with the oldest prediction
    always @(posedge aclk) begin
        pcm_item_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.first_sample    = m_tdata[15:0];
            got.second_sample   = m_tdata[31:16];
            got.sample_index    = m_tdata[55:32];
            got.loop_start_mark = m_tuser[0];
            got.looping_seen    = m_tuser[1];
            got.end_mark        = m_tuser[2];
            if (pcm_expected.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("item %0d unexpected: tdata %h tuser %b", rx_count, m_tdata,
                             m_tuser);
            end else begin
                want = pcm_expected.pop_front();
                if (got.first_sample !== want.first_sample ||
                    got.second_sample !== want.second_sample ||
                    got.sample_index !== want.sample_index ||
                    got.loop_start_mark !== want.loop_start_mark ||
                    got.looping_seen !== want.looping_seen ||
                    got.end_mark !== want.end_mark) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("item %0d mismatch: exp %0d %0d idx %0d marks %b%b%b,",
                                 rx_count, want.first_sample, want.second_sample,
                                 want.sample_index, want.loop_start_mark,
                                 want.looping_seen, want.end_mark,
                                 " got %0d %0d idx %0d marks %b%b%b",
                                 got.first_sample, got.second_sample, got.sample_index,
                                 got.loop_start_mark, got.looping_seen, got.end_mark);
                end
            end
            rx_count++;
        end
    end

    // stimulus sequence
    initial begin
        bit hold_done, pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            put_byte(directed_rows[i].stream_byte, directed_rows[i].start_of_sound,
                     directed_rows[i].has_fixed, directed_rows[i].fixed_res);

        while (bytes_sent < RANDOM_BYTES) begin
            // long receiver hold while bytes keep coming
            if (!hold_done && bytes_sent >= 350) begin
                rx_hold = 300;
                hold_done = 1'b1;
            end
            // sender waits for every pair to drain
            if (!pause_done && bytes_sent >= 650) begin
                s_tvalid <= 1'b0;
                while (pcm_expected.size() != 0) @(negedge aclk);
                pause_done = 1'b1;
            end
            // no idling in the last stretch
            if (bytes_sent >= 950) gaps_on = 1'b0;
            send_sound();
        end
        s_tvalid <= 1'b0;

        while (pcm_expected.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("adpcm_block_decoder_tb: PASS");
        end else begin
            $display("adpcm_block_decoder_tb: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("adpcm_block_decoder_tb: FAIL");
        $finish;
    end

endmodule
